### rtl/rig_pkg.sv
// ----------------------------------------------------------------------------
// rig_pkg: shared types and constants of the radical inverse generator
// Widths of the request and response fields, the radix register, the
// sequencer states and the operand groups of the shared divide step.
// ----------------------------------------------------------------------------
package rig_pkg;

   localparam int SAMPLE_INDEX_W = 32;
   localparam int FRACTION_W     = 32;
   localparam int RADIX_W        = 8;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 8'd2;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 8'd2;

   typedef logic [SAMPLE_INDEX_W-1:0] sample_index_type;
   typedef logic [FRACTION_W-1:0]     fraction_type;
   typedef logic [RADIX_W-1:0]        radix_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_POP,
      ST_MIX,
      ST_FINISH
   } state_type;

   // Operands of one restoring divide step
   typedef struct packed {
      radix_type rem;
      logic      dividend_bit;
      radix_type divisor;
   } div_in_type;

   typedef struct packed {
      radix_type rem;
      logic      quotient_bit;
   } div_out_type;

endpackage

### rtl/rig_req_if.sv
// ----------------------------------------------------------------------------
// rig_req_if: request channel of the radical inverse generator
// Valid/ready handshake carrying one sample index per request.
// ----------------------------------------------------------------------------
interface rig_req_if;
   logic                      valid;
   logic                      ready;
   rig_pkg::sample_index_type sample_index;

   modport source (output valid, output sample_index, input ready);
   modport sink   (input valid, input sample_index, output ready);
endinterface

### rtl/rig_rsp_if.sv
// ----------------------------------------------------------------------------
// rig_rsp_if: response channel of the radical inverse generator
// Valid/ready handshake carrying one binary fraction per response.
// ----------------------------------------------------------------------------
interface rig_rsp_if;
   logic                  valid;
   logic                  ready;
   rig_pkg::fraction_type fraction;

   modport source (output valid, output fraction, input ready);
   modport sink   (input valid, input fraction, output ready);
endinterface

### rtl/rig_div_step.sv
// ----------------------------------------------------------------------------
// rig_div_step: one restoring divide step by the radix
// Shifts one dividend bit into the partial remainder, compares against the
// divisor and subtracts when it fits; the remainder stays below the divisor.
// ----------------------------------------------------------------------------
module rig_div_step (
   input  rig_pkg::div_in_type  step_i,
   output rig_pkg::div_out_type step_o
);

   logic [rig_pkg::RADIX_W:0] trial;
   logic [rig_pkg::RADIX_W:0] divisor_ext;
   logic [rig_pkg::RADIX_W:0] diff;

   // Form the trial remainder and subtract when the divisor fits
   always_comb begin
      trial       = {step_i.rem, step_i.dividend_bit};
      divisor_ext = {1'b0, step_i.divisor};
      diff        = trial - divisor_ext;
      if (trial >= divisor_ext) begin
         step_o.rem          = diff[rig_pkg::RADIX_W-1:0];
         step_o.quotient_bit = 1'b1;
      end else begin
         step_o.rem          = trial[rig_pkg::RADIX_W-1:0];
         step_o.quotient_bit = 1'b0;
      end
   end

endmodule

### rtl/radical_inverse_generator.sv
// ----------------------------------------------------------------------------
// radical_inverse_generator: Halton radical inverse of a sample index
// Splits the index into radix digits and mirrors them about the radix point,
// giving an exact truncated binary fraction.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one sample index per request (valid/ready); only its low
//   INDEX_BITS bits are used. rsp returns one fraction per request, the
//   radical inverse scaled by 2^FRACTION_BITS and truncated. csr_wr_en and
//   csr_wr_data set the radix (values below 2 act as 2); write it only
//   while no request is in flight.
//   One request is worked on at a time and req.ready stays low meanwhile.
//   Every digit of the index in the radix is split off in INDEX_BITS
//   divide steps and folded into the fraction by one pop and
//   FRACTION_BITS divide steps, all on one shared one-bit divide step;
//   the output register is loaded last. Index 0 skips splitting and
//   folding and goes straight to the output register. req.ready rises
//   together with rsp.valid, so a new request is taken only once the
//   last result has reached the output register.
//   The result sits in an output register, so a new request is taken while
//   a finished one waits on a stalled receiver; the next result then waits
//   until the register is free.
//   Reset (synchronous) returns to idle, drops rsp.valid and sets radix 2.
// ----------------------------------------------------------------------------
module radical_inverse_generator #(
   parameter int INDEX_BITS    = 32,
   parameter int FRACTION_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   rig_req_if.sink                   req,
   rig_rsp_if.source                 rsp,
   input  logic                      csr_wr_en,
   input  logic [rig_pkg::RADIX_W-1:0] csr_wr_data
);

   localparam int WORK_W = (INDEX_BITS > FRACTION_BITS) ? INDEX_BITS : FRACTION_BITS;
   localparam int CNT_W  = $clog2(WORK_W);
   localparam int DEPTH  = INDEX_BITS;
   localparam int DCNT_W = $clog2(INDEX_BITS + 1);

   localparam logic [WORK_W-1:0] INDEX_MASK = {WORK_W{1'b1}} >> (WORK_W - INDEX_BITS);
   localparam logic [CNT_W-1:0]  SPLIT_LAST = CNT_W'(INDEX_BITS - 1);
   localparam logic [CNT_W-1:0]  MIX_LAST   = CNT_W'(FRACTION_BITS - 1);

   rig_pkg::state_type state_ff, state_in;
   rig_pkg::radix_type radix_ff, radix_in;
   rig_pkg::radix_type radix_eff;

   logic [WORK_W-1:0]                         work_ff, work_in;
   logic [WORK_W-1:0]                         work_shift;
   logic [WORK_W-1:0]                         idx_masked;
   rig_pkg::radix_type                        rem_ff, rem_in;
   logic [CNT_W-1:0]                          cnt_ff, cnt_in;
   logic [DCNT_W-1:0]                         dcnt_ff, dcnt_in;
   logic [DEPTH-1:0][rig_pkg::RADIX_W-1:0]    stack_ff, stack_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   rig_pkg::fraction_type rsp_fraction_ff, rsp_fraction_in;

   rig_pkg::div_in_type  step_in;
   rig_pkg::div_out_type step_out;

   logic accept;
   logic idx_zero;
   logic last_bit;
   logic quotient_zero;
   logic out_free;
   logic ready_out;
   logic mix_sel;

   // Shared divide step
   rig_div_step u_div_step (
      .step_i (step_in),
      .step_o (step_out)
   );

   // Status terms
   always_comb begin
      radix_eff     = (radix_ff < rig_pkg::RADIX_MIN) ? rig_pkg::RADIX_MIN : radix_ff;
      idx_masked    = WORK_W'(req.sample_index) & INDEX_MASK;
      idx_zero      = (idx_masked == '0);
      accept        = req.valid && ready_out;
      last_bit      = (cnt_ff == '0);
      work_shift    = {work_ff[WORK_W-2:0], step_out.quotient_bit};
      quotient_zero = ((work_shift & INDEX_MASK) == '0);
      out_free      = !rsp_valid_ff || rsp.ready;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rig_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = idx_zero ? rig_pkg::ST_FINISH : rig_pkg::ST_SPLIT;
            end
         end
         rig_pkg::ST_SPLIT: begin
            if (last_bit && quotient_zero) begin
               state_in = rig_pkg::ST_POP;
            end
         end
         rig_pkg::ST_POP: begin
            state_in = rig_pkg::ST_MIX;
         end
         rig_pkg::ST_MIX: begin
            if (last_bit) begin
               state_in = (dcnt_ff == '0) ? rig_pkg::ST_FINISH : rig_pkg::ST_POP;
            end
         end
         rig_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = rig_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rig_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      ready_out = 1'b0;
      mix_sel   = 1'b0;
      case (state_ff)
         rig_pkg::ST_IDLE: begin
            ready_out = 1'b1;
         end
         rig_pkg::ST_MIX: begin
            mix_sel = 1'b1;
         end
         default: begin
            ready_out = 1'b0;
            mix_sel   = 1'b0;
         end
      endcase
   end

   // Feed the divide step: index bits while splitting, fraction bits while mixing
   always_comb begin
      step_in.rem          = rem_ff;
      step_in.dividend_bit = mix_sel ? work_ff[FRACTION_BITS-1] : work_ff[INDEX_BITS-1];
      step_in.divisor      = radix_eff;
   end

   // Datapath next values
   always_comb begin
      work_in         = work_ff;
      rem_in          = rem_ff;
      cnt_in          = cnt_ff;
      dcnt_in         = dcnt_ff;
      stack_in        = stack_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_fraction_in = rsp_fraction_ff;
      radix_in        = csr_wr_en ? csr_wr_data : radix_ff;

      case (state_ff)
         rig_pkg::ST_IDLE: begin
            // Load the index; a zero index goes straight out as zero
            if (accept) begin
               work_in = idx_masked;
               rem_in  = '0;
               cnt_in  = SPLIT_LAST;
               dcnt_in = '0;
            end
         end
         rig_pkg::ST_SPLIT: begin
            // Divide the index by the radix one bit at a time
            work_in = work_shift;
            rem_in  = step_out.rem;
            cnt_in  = cnt_ff - CNT_W'(1);
            if (last_bit) begin
               // Push the digit, least significant first
               stack_in = {stack_ff[DEPTH-2:0], step_out.rem};
               dcnt_in  = dcnt_ff + DCNT_W'(1);
               rem_in   = '0;
               cnt_in   = SPLIT_LAST;
               if (quotient_zero) begin
                  work_in = '0;
               end
            end
         end
         rig_pkg::ST_POP: begin
            // Take the most significant remaining digit as the starting remainder
            rem_in   = stack_ff[0];
            stack_in = {rig_pkg::radix_type'(0), stack_ff[DEPTH-1:1]};
            dcnt_in  = dcnt_ff - DCNT_W'(1);
            cnt_in   = MIX_LAST;
         end
         rig_pkg::ST_MIX: begin
            // Advance acc = (digit * 2^FRACTION_BITS + acc) / radix
            work_in = work_shift;
            rem_in  = step_out.rem;
            cnt_in  = cnt_ff - CNT_W'(1);
         end
         rig_pkg::ST_FINISH: begin
            // Hand the fraction to the output register once it is free
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_fraction_in = rig_pkg::fraction_type'(work_ff[FRACTION_BITS-1:0]);
            end
         end
         default: begin
            work_in = work_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rig_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         radix_ff     <= rig_pkg::RADIX_RESET;
         cnt_ff       <= '0;
         dcnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         radix_ff     <= radix_in;
         cnt_ff       <= cnt_in;
         dcnt_ff      <= dcnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      work_ff         <= work_in;
      rem_ff          <= rem_in;
      stack_ff        <= stack_in;
      rsp_fraction_ff <= rsp_fraction_in;
   end

   assign req.ready    = ready_out;
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.fraction = rsp_fraction_ff;

endmodule

### rtl/rig_checker.sv
// ----------------------------------------------------------------------------
// rig_checker: port-level checks of the radical inverse generator
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module rig_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rig_pkg::fraction_type rsp_fraction
);

   // One request at a time: ready drops after a request is taken
   property p_one_in_flight;
      @(posedge clock) disable iff (reset)
         (req_valid && req_ready) |=> !req_ready;
   endproperty
   a_one_in_flight: assert property (p_one_in_flight)
      else $error("request taken while another is in flight");

   // Reset leaves the block idle with no response pending
   property p_reset_idle;
      @(posedge clock) reset |=> (req_ready && !rsp_valid);
   endproperty
   a_reset_idle: assert property (p_reset_idle)
      else $error("block not idle after reset");

   // A stalled response holds its value
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_fraction));
   endproperty
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("stalled response dropped or changed");

endmodule

bind radical_inverse_generator rig_checker u_rig_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_fraction (rsp.fraction)
);
